// ===== rtl/cssp_pkg.sv =====
// Shared types, constants and the sector skew table for the chunk stream sector placer.
`default_nettype none
package cssp_pkg;

	localparam int TRACK_COUNT_DEF = 35;
	localparam int TRACK_W = 7;
	localparam int SECTOR_W = 10;
	localparam int OFFSET_W = 18;
	localparam logic [SECTOR_W-1:0] SECTOR_MAX = 10'd1023;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [7:0] page_byte;
	} place_req_t;

	typedef struct packed {
		logic ok;
		logic [OFFSET_W-1:0] offset;
	} place_rsp_t;

	typedef struct packed {
		logic dest_valid;
		logic [OFFSET_W-1:0] dest_offset;
		logic end_of_stream;
		logic [1:0] status;
		logic [SECTOR_W-1:0] sectors_used;
	} result_t;

	// Physical sector to logical sector interleave.
	function automatic logic [3:0] skew(input logic [3:0] phys);
		logic [3:0] s;
		case (phys)
			4'h0: s = 4'h0;
			4'h1: s = 4'h7;
			4'h2: s = 4'hE;
			4'h3: s = 4'h6;
			4'h4: s = 4'hD;
			4'h5: s = 4'h5;
			4'h6: s = 4'hC;
			4'h7: s = 4'h4;
			4'h8: s = 4'hB;
			4'h9: s = 4'h3;
			4'hA: s = 4'hA;
			4'hB: s = 4'h2;
			4'hC: s = 4'h9;
			4'hD: s = 4'h1;
			4'hE: s = 4'h8;
			default: s = 4'hF;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cssp_place.sv =====
// Maps a sector number and byte index to an image offset, flagging bytes past the disk end.
`default_nettype none
module cssp_place #(
	parameter int TRACK_COUNT = cssp_pkg::TRACK_COUNT_DEF
) (
	input  wire logic [5:0] start_track,
	input  wire cssp_pkg::place_req_t req,
	output cssp_pkg::place_rsp_t rsp
);
	import cssp_pkg::*;

	logic [TRACK_W-1:0] track;

	assign track = {1'b0, start_track} + {1'b0, req.sector[SECTOR_W-1:4]};

	always_comb begin
		rsp.ok = (track < TRACK_W'(TRACK_COUNT)) && (req.sector != SECTOR_MAX);
		if (rsp.ok) begin
			rsp.offset = {track[5:0], skew(req.sector[3:0]), req.page_byte};
		end else begin
			rsp.offset = '0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cssp_parser.sv =====
// Stream parse state and the per-byte placement decision.
`default_nettype none
module cssp_parser #(
	parameter int TRACK_COUNT = cssp_pkg::TRACK_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire logic [7:0] data_byte,
	input  wire logic last_byte,
	input  wire logic [5:0] start_track,
	output cssp_pkg::result_t result
);
	import cssp_pkg::*;

	localparam logic [2:0] PH_CNT_LO = 3'd0;
	localparam logic [2:0] PH_CNT_HI = 3'd1;
	localparam logic [2:0] PH_HDR = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_HDR_FULL = 2'd2;
	localparam logic [1:0] ST_PAST_END = 2'd3;

	logic [2:0] phase_q, phase_n;
	logic [15:0] chunks_left_q, chunks_left_n;
	logic [7:0] header_index_q, header_index_n;
	logic [2:0] hdr_pos_q, hdr_pos_n;
	logic [15:0] chunk_length_q, chunk_length_n;
	logic [15:0] data_left_q, data_left_n;
	logic [SECTOR_W-1:0] sector_q, sector_n;
	logic [7:0] page_byte_q, page_byte_n;
	logic [1:0] error_q, error_n;

	place_req_t preq;
	place_rsp_t prsp;
	logic place_used;
	logic hdr_full;
	logic [1:0] status;

	cssp_place #(.TRACK_COUNT(TRACK_COUNT)) u_place (
		.start_track(start_track),
		.req(preq),
		.rsp(prsp)
	);

	always_comb begin
		phase_n = phase_q;
		chunks_left_n = chunks_left_q;
		header_index_n = header_index_q;
		hdr_pos_n = hdr_pos_q;
		chunk_length_n = chunk_length_q;
		data_left_n = data_left_q;
		sector_n = sector_q;
		page_byte_n = page_byte_q;
		preq.sector = '0;
		preq.page_byte = '0;
		place_used = 1'b0;
		hdr_full = 1'b0;

		case (phase_q)
			PH_CNT_LO: begin
				chunks_left_n = {8'd0, data_byte};
				place_used = 1'b1;
				header_index_n = 8'd1;
				phase_n = PH_CNT_HI;
			end
			PH_CNT_HI: begin
				chunks_left_n = chunks_left_q | {data_byte, 8'd0};
				hdr_pos_n = '0;
				phase_n = (chunks_left_n != '0) ? PH_HDR : PH_DONE;
			end
			PH_HDR: begin
				if (header_index_q == '0) begin
					hdr_full = 1'b1;
				end else begin
					place_used = 1'b1;
					preq.page_byte = header_index_q;
					header_index_n = header_index_q + 8'd1;
				end
				if (hdr_pos_q == 3'd3) begin
					chunk_length_n = {8'd0, data_byte};
				end else if (hdr_pos_q == 3'd4) begin
					chunk_length_n = chunk_length_q | {data_byte, 8'd0};
				end
				hdr_pos_n = hdr_pos_q + 3'd1;
				if (hdr_pos_n >= 3'd5) begin
					hdr_pos_n = '0;
					chunks_left_n = chunks_left_q - 16'd1;
					data_left_n = chunk_length_n;
					page_byte_n = '0;
					if (chunk_length_n == '0) begin
						phase_n = (chunks_left_n != '0) ? PH_HDR : PH_DONE;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				place_used = 1'b1;
				preq.sector = sector_q;
				preq.page_byte = page_byte_q;
				page_byte_n = page_byte_q + 8'd1;
				if (page_byte_q == 8'd255 && sector_q != SECTOR_MAX) begin
					sector_n = sector_q + SECTOR_W'(1);
				end
				data_left_n = data_left_q - 16'd1;
				// A chunk ending mid-sector closes that sector.
				if (data_left_n == '0) begin
					if (page_byte_n != '0) begin
						page_byte_n = '0;
						if (sector_q != SECTOR_MAX) begin
							sector_n = sector_q + SECTOR_W'(1);
						end
					end
					phase_n = (chunks_left_q != '0) ? PH_HDR : PH_DONE;
				end
			end
			default: begin
			end
		endcase

		error_n = error_q;
		if (error_q == ST_OK) begin
			if (hdr_full) begin
				error_n = ST_HDR_FULL;
			end else if (place_used && !prsp.ok) begin
				error_n = ST_PAST_END;
			end
		end

		status = error_n;
		if (last_byte && phase_n < PH_DONE) begin
			status = ST_TRUNC;
		end

		result.dest_valid = place_used && prsp.ok;
		result.dest_offset = (place_used && prsp.ok) ? prsp.offset : '0;
		result.end_of_stream = last_byte;
		result.status = status;
		result.sectors_used = sector_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CNT_LO;
			chunks_left_q <= '0;
			header_index_q <= '0;
			hdr_pos_q <= '0;
			chunk_length_q <= '0;
			data_left_q <= '0;
			sector_q <= SECTOR_W'(1);
			page_byte_q <= '0;
			error_q <= ST_OK;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_CNT_LO;
				chunks_left_q <= '0;
				header_index_q <= '0;
				hdr_pos_q <= '0;
				chunk_length_q <= '0;
				data_left_q <= '0;
				sector_q <= SECTOR_W'(1);
				page_byte_q <= '0;
				error_q <= ST_OK;
			end else begin
				phase_q <= phase_n;
				chunks_left_q <= chunks_left_n;
				header_index_q <= header_index_n;
				hdr_pos_q <= hdr_pos_n;
				chunk_length_q <= chunk_length_n;
				data_left_q <= data_left_n;
				sector_q <= sector_n;
				page_byte_q <= page_byte_n;
				error_q <= error_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chunk_stream_sector_placer_top.sv =====
// Top level of the chunk stream sector placer: config register, parser and result register.
// The result of an accepted input byte is captured in the result register.
// Throughput: one byte per cycle while not stalled; the result register holds while full and out_stall is high,
// and a new request is taken whenever that register is empty or being drained.
// Reset: arst_n clears the parse state and sets start_track to 12; a byte with
// last_byte set also returns the parse state to its reset values, keeping start_track.
`default_nettype none
module chunk_stream_sector_placer_top #(
	parameter int TRACK_COUNT = cssp_pkg::TRACK_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [5:0] cfg_wr_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic last_byte,
	output logic out_valid,
	input  wire logic out_stall,
	output logic dest_valid,
	output logic [cssp_pkg::OFFSET_W-1:0] dest_offset,
	output logic end_of_stream,
	output logic [1:0] status,
	output logic [cssp_pkg::SECTOR_W-1:0] sectors_used
);
	import cssp_pkg::*;

	logic [5:0] start_track_q;
	logic out_valid_q;
	result_t result;
	result_t result_q;
	logic accept;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_track_q <= 6'd12;
		end else if (cfg_wr_en) begin
			start_track_q <= cfg_wr_data;
		end
	end

	cssp_parser #(.TRACK_COUNT(TRACK_COUNT)) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.start_track(start_track_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign dest_valid = result_q.dest_valid;
	assign dest_offset = result_q.dest_offset;
	assign end_of_stream = result_q.end_of_stream;
	assign status = result_q.status;
	assign sectors_used = result_q.sectors_used;

endmodule
`default_nettype wire

// ===== tb/tb_chunk_stream_sector_placer_top.sv =====
// Self-checking testbench for the chunk stream sector placer: directed table, random streams, predictor.
module tb_chunk_stream_sector_placer_top;

	import cssp_pkg::*;

	localparam int TRACKS = TRACK_COUNT_DEF;
	localparam int RANDOM_BYTES = 1200;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 16;
	localparam logic [3:0] SKEW_LUT [16] = '{4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF};

	typedef enum logic [2:0] {PH_COUNT_LO, PH_COUNT_HI, PH_HEADER, PH_DATA, PH_DONE} parse_e;
	typedef enum logic [1:0] {ST_OK, ST_TRUNC, ST_HDR_FULL, ST_PAST_END} status_e;
	typedef enum int {SK_CLEAN, SK_CUT, SK_NOISE, SK_FILL} stream_e;

	typedef struct {
		logic [7:0] b;
		logic l;
		logic pin;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [5:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic last_byte;
	logic out_valid;
	logic out_stall;
	logic dest_valid;
	logic [OFFSET_W-1:0] dest_offset;
	logic end_of_stream;
	logic [1:0] status;
	logic [SECTOR_W-1:0] sectors_used;

	// Pinned expectation that travels with a directed request.
	logic row_pin;
	result_t row_want;

	result_t placements_due[$];
	dir_row_t dir_tab[$];
	logic [7:0] stream_q[$];
	int mismatches = 0;
	int cycles = 0;
	int tx_pct = IDLE_PCT;
	int rx_pct = IDLE_PCT;
	bit hold_pending = 1'b0;

	// Predictor state.
	logic [5:0] cfg_track = 6'd12;
	parse_e phase;
	logic [15:0] chunks_rem;
	logic [7:0] hdr_idx;
	logic [2:0] hdr_pos;
	logic [15:0] chunk_len;
	logic [15:0] bytes_rem;
	logic [SECTOR_W-1:0] sector;
	logic [7:0] sec_byte;
	logic [1:0] err;

	chunk_stream_sector_placer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dest_valid(dest_valid),
		.dest_offset(dest_offset),
		.end_of_stream(end_of_stream),
		.status(status),
		.sectors_used(sectors_used)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_parse();
		phase = PH_COUNT_LO;
		chunks_rem = '0;
		hdr_idx = '0;
		hdr_pos = '0;
		chunk_len = '0;
		bytes_rem = '0;
		sector = 10'd1;
		sec_byte = '0;
		err = ST_OK;
	endfunction

	function automatic void latch_error(input status_e code);
		if (err == ST_OK)
			err = code;
	endfunction

	function automatic parse_e after_chunk();
		return (chunks_rem != 0) ? PH_HEADER : PH_DONE;
	endfunction

	function automatic logic map_sector(input logic [SECTOR_W-1:0] sec, input logic [7:0] pb,
			output logic [OFFSET_W-1:0] off);
		int unsigned trk;
		trk = cfg_track + sec / 16;
		if (trk >= TRACKS || sec == SECTOR_MAX) begin
			latch_error(ST_PAST_END);
			off = '0;
			return 1'b0;
		end
		off = OFFSET_W'(trk * 4096 + SKEW_LUT[sec[3:0]] * 256 + pb);
		return 1'b1;
	endfunction

	function automatic result_t place_byte(input logic [7:0] b, input logic l);
		result_t r;
		logic ok;
		logic [OFFSET_W-1:0] off;
		ok = 1'b0;
		off = '0;
		case (phase)
			PH_COUNT_LO: begin
				chunks_rem = {8'h00, b};
				ok = map_sector('0, 8'h00, off);
				hdr_idx = 8'd1;
				phase = PH_COUNT_HI;
			end
			PH_COUNT_HI: begin
				chunks_rem[15:8] = b;
				hdr_pos = '0;
				phase = after_chunk();
			end
			PH_HEADER: begin
				// The header sector is full once its byte index wraps to zero.
				if (hdr_idx == 0) begin
					latch_error(ST_HDR_FULL);
				end else begin
					ok = map_sector('0, hdr_idx, off);
					hdr_idx = hdr_idx + 8'd1;
				end
				if (hdr_pos == 3)
					chunk_len = {8'h00, b};
				else if (hdr_pos == 4)
					chunk_len[15:8] = b;
				hdr_pos++;
				if (hdr_pos >= 5) begin
					hdr_pos = '0;
					chunks_rem--;
					bytes_rem = chunk_len;
					sec_byte = '0;
					phase = (bytes_rem == 0) ? after_chunk() : PH_DATA;
				end
			end
			PH_DATA: begin
				ok = map_sector(sector, sec_byte, off);
				if (sec_byte == 8'hFF) begin
					sec_byte = '0;
					if (sector != SECTOR_MAX)
						sector++;
				end else begin
					sec_byte++;
				end
				bytes_rem--;
				if (bytes_rem == 0) begin
					// A partially filled sector is closed when its chunk ends.
					if (sec_byte != 0) begin
						sec_byte = '0;
						if (sector != SECTOR_MAX)
							sector++;
					end
					phase = after_chunk();
				end
			end
			default: begin
			end
		endcase
		r.dest_valid = ok;
		r.dest_offset = ok ? off : '0;
		r.end_of_stream = l;
		r.status = (l && phase != PH_DONE) ? ST_TRUNC : err;
		r.sectors_used = sector;
		if (l)
			clear_parse();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		result_t want;
		if (placements_due.size() == 0) begin
			report_mismatch("unexpected result", 1, 0);
		end else begin
			want = placements_due.pop_front();
			if (dest_valid !== want.dest_valid)
				report_mismatch("dest_valid", dest_valid, want.dest_valid);
			if (dest_offset !== want.dest_offset)
				report_mismatch("dest_offset", dest_offset, want.dest_offset);
			if (end_of_stream !== want.end_of_stream)
				report_mismatch("end_of_stream", end_of_stream, want.end_of_stream);
			if (status !== want.status)
				report_mismatch("status", status, want.status);
			if (sectors_used !== want.sectors_used)
				report_mismatch("sectors_used", sectors_used, want.sectors_used);
		end
	endtask

	always @(posedge clk) begin : monitor
		result_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_wr_en)
				cfg_track = cfg_wr_data;
			if (in_valid && !in_stall) begin
				pred = place_byte(data_byte, last_byte);
				placements_due.push_back(row_pin ? row_want : pred);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_chunk_stream_sector_placer_top: errors");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off that backs the block up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
		end
	end

	// Entered and left at a falling edge; in_valid stays high after the request is taken.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic pin,
			input result_t want);
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		row_pin <= pin;
		row_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_track(input logic [5:0] trk);
		in_valid <= 1'b0;
		while (placements_due.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= trk;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_row(input logic [7:0] b, input logic l, input logic pin, input logic dv,
			input int off, input logic eos, input status_e st, input int su);
		dir_row_t row;
		row.b = b;
		row.l = l;
		row.pin = pin;
		row.want.dest_valid = dv;
		row.want.dest_offset = OFFSET_W'(off);
		row.want.end_of_stream = eos;
		row.want.status = st;
		row.want.sectors_used = SECTOR_W'(su);
		dir_tab.push_back(row);
	endtask

	task automatic build_stream(input stream_e kind);
		int n;
		int len;
		int r;
		int cut;
		stream_q.delete();
		if (kind == SK_NOISE) begin
			repeat ($urandom_range(1, 12))
				stream_q.push_back(8'($urandom));
		end else begin
			r = $urandom_range(99);
			if (kind == SK_FILL)
				n = 60;
			else if (r < 5)
				n = 0;
			else if (r < 15)
				n = $urandom_range(52, 60);
			else if (r < 35)
				n = $urandom_range(10, 24);
			else
				n = $urandom_range(1, 6);
			stream_q.push_back(n[7:0]);
			stream_q.push_back(n[15:8]);
			repeat (n) begin
				repeat (3)
					stream_q.push_back(8'($urandom));
				r = $urandom_range(99);
				if (kind == SK_FILL)
					len = 1;
				else if (n > 51)
					len = $urandom_range(0, 3);
				else if (n > 6)
					len = $urandom_range(1, 20);
				else if (r < 15)
					len = 0;
				else if (r < 25)
					len = $urandom_range(200, 600);
				else
					len = $urandom_range(1, 40);
				stream_q.push_back(len[7:0]);
				stream_q.push_back(len[15:8]);
				repeat (len)
					stream_q.push_back(8'($urandom));
			end
			if (kind != SK_FILL && $urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3))
					stream_q.push_back(8'($urandom));
			end
			if (kind == SK_CUT && stream_q.size() > 1) begin
				cut = $urandom_range(1, stream_q.size() - 1);
				while (stream_q.size() > cut)
					void'(stream_q.pop_back());
			end
		end
	endtask

	initial begin : stimulus
		int fed;
		int n_streams;
		int r;
		stream_e kind;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		row_pin = 1'b0;
		row_want = '0;
		clear_parse();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Reset track 12: two chunks, the second of zero length, then a trailing byte.
		add_row(8'h02, 0, 1, 1, 49152, 0, ST_OK, 1);
		add_row(8'h00, 0, 1, 0, 0, 0, ST_OK, 1);
		add_row(8'hFF, 0, 1, 1, 49153, 0, ST_OK, 1);
		add_row(8'h00, 0, 1, 1, 49154, 0, ST_OK, 1);
		add_row(8'hA5, 0, 1, 1, 49155, 0, ST_OK, 1);
		add_row(8'h01, 0, 1, 1, 49156, 0, ST_OK, 1);
		add_row(8'h00, 0, 1, 1, 49157, 0, ST_OK, 1);
		add_row(8'hFF, 0, 1, 1, 50944, 0, ST_OK, 2);
		add_row(8'h00, 0, 1, 1, 49158, 0, ST_OK, 2);
		add_row(8'h80, 0, 1, 1, 49159, 0, ST_OK, 2);
		add_row(8'h01, 0, 1, 1, 49160, 0, ST_OK, 2);
		add_row(8'h00, 0, 1, 1, 49161, 0, ST_OK, 2);
		add_row(8'h00, 0, 1, 1, 49162, 0, ST_OK, 2);
		add_row(8'h5A, 1, 1, 0, 0, 1, ST_OK, 2);
		// Maximum chunk count cut off right after the count.
		add_row(8'hFF, 0, 1, 1, 49152, 0, ST_OK, 1);
		add_row(8'hFF, 1, 1, 0, 0, 1, ST_TRUNC, 1);
		// A stream of one byte.
		add_row(8'h00, 1, 1, 1, 49152, 1, ST_TRUNC, 1);
		// Cut off inside the data of a three-byte chunk.
		add_row(8'h01, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h00, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h12, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h34, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h56, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h03, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h00, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(8'h77, 1, 1, 1, 50944, 1, ST_TRUNC, 1);
		foreach (dir_tab[i])
			send_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].pin, dir_tab[i].want);

		fed = 0;
		n_streams = 0;
		set_track(6'd34);
		while (fed < RANDOM_BYTES) begin
			if (n_streams == 1) begin
				// Enough one-byte chunks to overflow the header, sent while the result
				// side is held off.
				set_track(6'd0);
				tx_pct = 0;
				rx_pct = 0;
				hold_pending = 1'b1;
				kind = SK_FILL;
			end else begin
				if ($urandom_range(2) == 0) begin
					r = $urandom_range(99);
					if (r < 30)
						set_track(6'd34);
					else if (r < 45)
						set_track(6'd0);
					else if (r < 60)
						set_track(6'd33);
					else
						set_track(6'($urandom_range(0, TRACKS - 1)));
				end
				tx_pct = (n_streams % 10 == 4) ? 0 : IDLE_PCT;
				rx_pct = tx_pct;
				r = $urandom_range(99);
				kind = (r < 70) ? SK_CLEAN : (r < 90) ? SK_CUT : SK_NOISE;
			end
			build_stream(kind);
			foreach (stream_q[i])
				send_byte(stream_q[i], i == stream_q.size() - 1, 1'b0, '0);
			fed += stream_q.size();
			n_streams++;
		end

		in_valid <= 1'b0;
		while (placements_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("tb_chunk_stream_sector_placer_top: clean");
		else
			$display("tb_chunk_stream_sector_placer_top: errors");
		$finish;
	end

endmodule

// ===== chunk_stream_sector_placer_top.f =====
rtl/cssp_pkg.sv
rtl/cssp_place.sv
rtl/cssp_parser.sv
rtl/chunk_stream_sector_placer_top.sv
tb/tb_chunk_stream_sector_placer_top.sv
